// ===== rtl/core/csrs_pkg.sv =====
`timescale 1ns / 1ps

package csrs_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CLIENT_W   = 8;
  localparam int unsigned AMOUNT_W   = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned BUDGET_W   = 16;
  localparam int unsigned DIVISOR_W  = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ENTRY_W    = CLIENT_W + AMOUNT_W;
  localparam int unsigned DIV_STEPS  = BUDGET_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [BUDGET_W-1:0]  BUDGET_RESET  = BUDGET_W'(1000);
  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = DIVISOR_W'(10);

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_SERVE   = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_IDLE     = 3'd3,
    ST_REFILLED = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_REFILL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/credit_share_request_scheduler_top.sv =====
`timescale 1ns / 1ps

// Credit-share request scheduler: a FIFO of pending requests (client tag and
// block amount) and one shared block budget. Enqueue, refill-tick and unused
// items, and a serve on an empty FIFO or a zero budget, are handled when
// accepted and yield their result on the next edge. A serve item on a
// non-empty FIFO with a non-zero budget waits for the 16-step restoring
// divider that works out budget / share_divisor one quotient bit a cycle.
// The input is not ready while a serve is in progress or while a result is
// still held and not being taken. Every item gives exactly one result.
module credit_share_request_scheduler_top import csrs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BUDGET_W-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [CLIENT_W-1:0]  client_i,
  input  logic [AMOUNT_W-1:0]  amount_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [CLIENT_W-1:0]  grant_client_o,
  output logic [AMOUNT_W-1:0]  granted_o,
  output logic [AMOUNT_W-1:0]  left_over_o,
  output logic [BUDGET_W-1:0]  budget_left_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic                 state_q, state_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [PTR_W-1:0]     tail_q, tail_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [BUDGET_W-1:0]  budget_q, budget_d;
  logic [BUDGET_W-1:0]  refill_q;
  logic [DIVISOR_W-1:0] divisor_q;

  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [CLIENT_W-1:0]  gclient_q, gclient_d;
  logic [AMOUNT_W-1:0]  granted_q, granted_d;
  logic [AMOUNT_W-1:0]  left_q, left_d;
  logic [BUDGET_W-1:0]  bleft_q, bleft_d;

  logic                 in_acc;
  logic                 full;
  logic                 div_start;
  logic [DIVISOR_W-1:0] div_eff;
  div_stat_t            div_stat;
  logic [BUDGET_W-1:0]  cap;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   head_entry;
  logic [CLIENT_W-1:0]  head_client;
  logic [AMOUNT_W-1:0]  head_amount;
  logic [AMOUNT_W-1:0]  grant;
  logic [AMOUNT_W-1:0]  remain;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign full        = fill_q == CNT_W'(QUEUE_DEPTH);
  assign div_eff     = (divisor_q == '0) ? DIVISOR_W'(1) : divisor_q;

  assign head_client = head_entry[ENTRY_W-1:AMOUNT_W];
  assign head_amount = head_entry[AMOUNT_W-1:0];
  assign grant       = (head_amount > cap) ? cap : head_amount;
  assign remain      = head_amount - grant;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  csrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (budget_q),
    .divisor_i  (div_eff),
    .stat_o     (div_stat),
    .quotient_o (cap)
  );

  csrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (head_entry)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    budget_d    = budget_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    gclient_d   = gclient_q;
    granted_d   = granted_q;
    left_d      = left_q;
    bleft_d     = bleft_q;
    div_start   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = tail_q;
    ram_wdata   = {client_i, amount_i};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          status_d    = ST_IDLE;
          gclient_d   = '0;
          granted_d   = '0;
          left_d      = '0;
          bleft_d     = budget_q;
          unique case (kind_e'(kind_i))
            KIND_ENQUEUE: begin
              if (full) begin
                status_d = ST_DROPPED;
              end else begin
                ram_we   = 1'b1;
                tail_d   = ptr_next(tail_q);
                fill_d   = fill_q + 1'b1;
                status_d = ST_QUEUED;
              end
            end
            KIND_TICK: begin
              budget_d = refill_q;
              bleft_d  = refill_q;
              status_d = ST_REFILLED;
            end
            KIND_SERVE: begin
              if (fill_q != '0 && budget_q != '0) begin
                // hold the result until the cap is known
                out_valid_d = 1'b0;
                div_start   = 1'b1;
                state_d     = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          head_d   = ptr_next(head_q);
          budget_d = budget_q - grant;
          if (remain != '0) begin
            // rotate the entry to the tail; the pop leaves room for it
            ram_we    = 1'b1;
            ram_wdata = {head_client, remain};
            tail_d    = ptr_next(tail_q);
          end else begin
            fill_d = fill_q - 1'b1;
          end
          out_valid_d = 1'b1;
          status_d    = ST_GRANTED;
          gclient_d   = head_client;
          granted_d   = grant;
          left_d      = remain;
          bleft_d     = budget_q - grant;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      budget_q    <= BUDGET_RESET;
      refill_q    <= BUDGET_RESET;
      divisor_q   <= DIVISOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      budget_q    <= budget_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_REFILL) begin
          refill_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_DIVISOR) begin
          divisor_q <= cfg_data_i[DIVISOR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    gclient_q <= gclient_d;
    granted_q <= granted_d;
    left_q    <= left_d;
    bleft_q   <= bleft_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign grant_client_o = gclient_q;
  assign granted_o      = granted_q;
  assign left_over_o    = left_q;
  assign budget_left_o  = bleft_q;

  // tail must always sit fill entries past head, modulo the depth
  logic [CNT_W:0] ptr_sum;
  logic [CNT_W:0] ptr_wrap;
  assign ptr_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(fill_q);
  assign ptr_wrap = (ptr_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                    ptr_sum - (CNT_W+1)'(QUEUE_DEPTH) : ptr_sum;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count exceeds queue depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_wrap == (CNT_W+1)'(tail_q))
    else $error("head, tail and fill count disagree");

  a_budget_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !(in_acc && kind_i == KIND_TICK)) |=>
      (budget_q <= $past(budget_q)))
    else $error("budget grew without a refill tick");

  a_serve_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_stat.done) |=> (out_valid_q && state_q == S_IDLE))
    else $error("serve finished without a result");

endmodule

// ===== rtl/core/csrs_ram.sv =====
`timescale 1ns / 1ps

module csrs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/csrs_div.sv =====
`timescale 1ns / 1ps

module csrs_div import csrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [BUDGET_W-1:0]  dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output div_stat_t            stat_o,
  output logic [BUDGET_W-1:0]  quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] div_q, div_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [BUDGET_W-1:0]  quo_q, quo_d;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[BUDGET_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, div_q}) : DIVISOR_W'(trial);
      quo_d = {quo_q[BUDGET_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== tb/csrs_grant_checker.sv =====
`timescale 1ns / 1ps

module csrs_grant_checker import csrs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BUDGET_W-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [CLIENT_W-1:0]  client_i,
  input  logic [AMOUNT_W-1:0]  amount_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [STATUS_W-1:0]  status_i,
  input  logic [CLIENT_W-1:0]  grant_client_i,
  input  logic [AMOUNT_W-1:0]  granted_i,
  input  logic [AMOUNT_W-1:0]  left_over_i,
  input  logic [BUDGET_W-1:0]  budget_left_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  typedef struct packed {
    status_e               status;
    logic [CLIENT_W-1:0]   client;
    logic [AMOUNT_W-1:0]   granted;
    logic [AMOUNT_W-1:0]   left_over;
    logic [BUDGET_W-1:0]   budget;
  } sched_result_t;

  logic [ENTRY_W-1:0]   request_q [QUEUE_DEPTH];
  int unsigned          head_m;
  int unsigned          tail_m;
  int unsigned          fill_m;
  logic [BUDGET_W-1:0]  budget_m;
  logic [BUDGET_W-1:0]  refill_m;
  logic [DIVISOR_W-1:0] divisor_m;
  sched_result_t        due_results [$];
  sched_result_t        oldest;
  int                   errors = 0;

  assign mismatches_o = errors;

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
    end
  endtask

  function automatic int unsigned wrap_next(int unsigned i);
    return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
  endfunction

  function automatic void push_request(logic [ENTRY_W-1:0] entry);
    request_q[tail_m] = entry;
    tail_m = wrap_next(tail_m);
    fill_m++;
  endfunction

  function automatic sched_result_t apply_item(kind_e k, logic [CLIENT_W-1:0] c,
                                               logic [AMOUNT_W-1:0] a);
    sched_result_t        res;
    logic [BUDGET_W-1:0]  div;
    logic [BUDGET_W-1:0]  cap;
    logic [ENTRY_W-1:0]   entry;
    logic [AMOUNT_W-1:0]  owed;
    logic [AMOUNT_W-1:0]  give;
    res = '0;
    res.status = ST_IDLE;
    case (k)
      KIND_ENQUEUE: begin
        if (fill_m < QUEUE_DEPTH) begin
          push_request({c, a});
          res.status = ST_QUEUED;
        end else begin
          res.status = ST_DROPPED;
        end
      end
      KIND_TICK: begin
        budget_m = refill_m;
        res.status = ST_REFILLED;
      end
      KIND_SERVE: begin
        if (fill_m != 0 && budget_m != 0) begin
          // a divisor of zero acts as one
          div = (divisor_m == '0) ? BUDGET_W'(1) : BUDGET_W'(divisor_m);
          cap = budget_m / div;
          entry = request_q[head_m];
          head_m = wrap_next(head_m);
          fill_m--;
          owed = entry[AMOUNT_W-1:0];
          give = (owed > cap) ? cap : owed;
          budget_m = budget_m - give;
          // rotate to the tail while anything is still owed, even after a zero grant
          if (owed != give) begin
            push_request({entry[ENTRY_W-1:AMOUNT_W], owed - give});
          end
          res.status = ST_GRANTED;
          res.client = entry[ENTRY_W-1:AMOUNT_W];
          res.granted = give;
          res.left_over = owed - give;
        end
      end
      default: ;
    endcase
    res.budget = budget_m;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_m = 0;
      tail_m = 0;
      fill_m = 0;
      budget_m = BUDGET_RESET;
      refill_m = BUDGET_RESET;
      divisor_m = DIVISOR_RESET;
      due_results.delete();
      pending_o <= 0;
    end else begin
      // check the outgoing item before predicting the incoming one
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding, status %0d", status_i));
        end else begin
          oldest = due_results.pop_front();
          compare_field("status", status_i, oldest.status);
          compare_field("grant_client", grant_client_i, oldest.client);
          compare_field("granted", granted_i, oldest.granted);
          compare_field("left_over", left_over_i, oldest.left_over);
          compare_field("budget_left", budget_left_i, oldest.budget);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_REFILL:  refill_m = cfg_data_i;
          CFG_DIVISOR: divisor_m = cfg_data_i[DIVISOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        due_results.push_back(apply_item(kind_e'(kind_i), client_i, amount_i));
      end
      pending_o <= due_results.size();
    end
  end

endmodule

// ===== tb/credit_share_request_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module credit_share_request_scheduler_top_tb;
  import csrs_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 72;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_REFILL;
  logic [BUDGET_W-1:0]  cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i      = KIND_ENQUEUE;
  logic [CLIENT_W-1:0]  client_i    = '0;
  logic [AMOUNT_W-1:0]  amount_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [CLIENT_W-1:0]  grant_client_o;
  logic [AMOUNT_W-1:0]  granted_o;
  logic [AMOUNT_W-1:0]  left_over_o;
  logic [BUDGET_W-1:0]  budget_left_o;

  logic        steady = 1'b0;
  int          mismatches;
  int          outstanding;
  int unsigned stall_cycles = 0;

  always #2 clk_i = ~clk_i;

  credit_share_request_scheduler_top #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .client_i      (client_i),
    .amount_i      (amount_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .grant_client_o(grant_client_o),
    .granted_o     (granted_o),
    .left_over_o   (left_over_o),
    .budget_left_o (budget_left_o)
  );

  csrs_grant_checker #(
    .QUEUE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .client_i      (client_i),
    .amount_i      (amount_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .grant_client_i(grant_client_o),
    .granted_i     (granted_o),
    .left_over_i   (left_over_o),
    .budget_left_i (budget_left_o),
    .mismatches_o  (mismatches),
    .pending_o     (outstanding)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(kind_e k, logic [CLIENT_W-1:0] c, logic [AMOUNT_W-1:0] a);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    kind_i     <= k;
    client_i   <= c;
    amount_i   <= a;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_item(int unsigned enq_pct);
    int unsigned         roll;
    kind_e               k;
    logic [AMOUNT_W-1:0] amt;
    roll = $urandom_range(99);
    if (roll < enq_pct) k = KIND_ENQUEUE;
    else if (roll < enq_pct + 8) k = KIND_TICK;
    else if (roll < enq_pct + 11) k = KIND_UNUSED;
    else k = KIND_SERVE;
    // mostly small amounts so requests drain, now and then the full range
    amt = ($urandom_range(5) == 0) ? AMOUNT_W'($urandom_range(65535))
                                   : AMOUNT_W'($urandom_range(400));
    send_item(k, CLIENT_W'($urandom_range(255)), amt);
  endtask

  // hold off until every item in flight has produced its result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BUDGET_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(logic [BUDGET_W-1:0] refill, logic [DIVISOR_W-1:0] div);
    drain();
    write_reg(CFG_REFILL, refill);
    write_reg(CFG_DIVISOR, BUDGET_W'(div));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, unused kind, field extremes, zero-amount request
    send_item(KIND_SERVE, 8'd0, 16'd0);
    send_item(KIND_UNUSED, 8'hFF, 16'hFFFF);
    send_item(KIND_ENQUEUE, 8'hFF, 16'hFFFF);
    send_item(KIND_ENQUEUE, 8'h00, 16'h0000);
    send_item(KIND_ENQUEUE, 8'h5A, 16'hA5A5);
    send_item(KIND_SERVE, 8'hFF, 16'hFFFF);
    send_item(KIND_SERVE, 8'd0, 16'd0);
    send_item(KIND_SERVE, 8'd0, 16'd0);
    send_item(KIND_TICK, 8'hA5, 16'h5A5A);
    send_item(KIND_SERVE, 8'd0, 16'd0);

    // budget below the divisor: zero grant, entry still rotates
    set_config(16'd5, 10'd10);
    send_item(KIND_TICK, 8'd0, 16'd0);
    send_item(KIND_SERVE, 8'd0, 16'd0);
    send_item(KIND_SERVE, 8'd0, 16'd0);

    // zero budget and zero divisor
    set_config(16'd0, 10'd0);
    send_item(KIND_TICK, 8'd0, 16'd0);
    send_item(KIND_SERVE, 8'd0, 16'd0);
    send_item(KIND_ENQUEUE, 8'd1, 16'd3);

    set_config(16'hFFFF, 10'd0);
    send_item(KIND_TICK, 8'd0, 16'd0);
    send_item(KIND_SERVE, 8'd0, 16'd0);
    send_item(KIND_SERVE, 8'd0, 16'd0);
    send_item(KIND_SERVE, 8'd0, 16'd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(16'hFFFF, 10'd1);
        1: set_config(16'd2000, 10'd1023);
        2: set_config(16'd0, 10'd7);
        4: set_config(16'd300, 10'd3);
        default: set_config(BUDGET_W'($urandom_range(65535)),
                            DIVISOR_W'($urandom_range(1, 1023)));
      endcase
      steady <= (p == 3);
      send_item(KIND_TICK, CLIENT_W'($urandom_range(255)), AMOUNT_W'($urandom_range(65535)));
      repeat (PHASE_ITEMS) random_item((p == 2 || p == 4) ? 60 : 42);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
